### rtl/lbe_pkg.sv
package lbe_pkg;

   // Field widths.
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned PIPE_DEPTH = 13;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_OLD_VEL_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OLD_VEL_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OLD_VEL_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEW_VEL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEW_VEL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEW_VEL_Z = 3'd5;

   // Magnitude limit of an intermediate product, 2^62.
   localparam logic [62:0] CLAMP_LIM = 63'h4000_0000_0000_0000;
   // Gamma of exactly 1.0 in Q32.32.
   localparam logic [62:0] ONE_Q32 = 63'h0000_0001_0000_0000;

   // Input event.
   typedef struct packed {
      logic signed [DATA_W-1:0] event_t;
      logic signed [DATA_W-1:0] event_x;
      logic signed [DATA_W-1:0] event_y;
      logic signed [DATA_W-1:0] event_z;
   } lbe_req_type;

   // Boosted event.
   typedef struct packed {
      logic signed [DATA_W-1:0] boosted_t;
      logic signed [DATA_W-1:0] boosted_x;
      logic signed [DATA_W-1:0] boosted_y;
      logic signed [DATA_W-1:0] boosted_z;
      logic                     speed_invalid;
      logic                     clipped;
   } lbe_rsp_type;

   // Boost coefficients, fixed while events stream.
   typedef struct packed {
      logic [62:0]       g;
      logic [62:0]       k;
      logic              invalid;
      logic [2:0][30:0]  b;
      logic [2:0][29:0]  bmag;
      logic [2:0]        bneg;
   } lbe_coef_type;

   // Limit a product magnitude to 2^62.
   function automatic logic [62:0] clamp62(input logic [95:0] v);
      logic [62:0] r;
      if (v > 96'(CLAMP_LIM)) begin
         r = CLAMP_LIM;
      end else begin
         r = v[62:0];
      end
      return r;
   endfunction

   // Saturate to 32 bits; the top bit of the result is the clip flag.
   function automatic logic [32:0] sat32(input logic signed [64:0] v);
      logic [32:0] r;
      if (v > 65'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -65'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

### rtl/lbe_coef.sv
module lbe_coef (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbe_pkg::DATA_W-1:0]         csr_data,
   output logic                               calc_busy,
   output lbe_pkg::lbe_coef_type              coef
);

   localparam logic [2:0] CO_IDLE = 3'd0;
   localparam logic [2:0] CO_SQ   = 3'd1;
   localparam logic [2:0] CO_PREP = 3'd2;
   localparam logic [2:0] CO_ROOT = 3'd3;
   localparam logic [2:0] CO_DIVG = 3'd4;
   localparam logic [2:0] CO_DIVK = 3'd5;

   logic signed [31:0] old_ff [3];
   logic signed [31:0] new_ff [3];
   logic               dirty_ff;
   logic [2:0]         state_ff;
   logic [6:0]         cnt_ff;
   logic signed [32:0] b_ff [3];
   logic signed [65:0] sq_ff;
   logic [66:0]        acc_ff;
   logic [63:0]        n_ff, res_ff, bit_ff;
   logic [64:0]        dvd_ff, quo_ff;
   logic [63:0]        rem_ff, dvs_ff;
   logic [62:0]        g_ff, k_ff;
   logic               inv_ff;
   logic [2:0][29:0]   bmag_ff;
   logic [2:0]         bneg_ff;

   logic               wr_in;
   logic signed [32:0] bsel_in;
   logic [63:0]        rb_in, n_in, res_in;
   logic [64:0]        tr_in, quo_in;
   logic [63:0]        rem_in;
   logic               qb_in;
   logic               inv_in;

   assign csr_ready = (state_ff == CO_IDLE) && !reset;
   assign wr_in     = csr_valid && csr_ready;
   assign calc_busy = dirty_ff || (state_ff != CO_IDLE);

   assign coef.g       = g_ff;
   assign coef.k       = k_ff;
   assign coef.invalid = inv_ff;
   assign coef.b[0]    = b_ff[0][30:0];
   assign coef.b[1]    = b_ff[1][30:0];
   assign coef.b[2]    = b_ff[2][30:0];
   assign coef.bmag    = bmag_ff;
   assign coef.bneg    = bneg_ff;

   // Beta component squared in the current step.
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    bsel_in = b_ff[0];
         2'd1:    bsel_in = b_ff[1];
         default: bsel_in = b_ff[2];
      endcase
   end

   // One step of the bitwise square root.
   always_comb begin
      rb_in = res_ff + bit_ff;
      if (n_ff >= rb_in) begin
         n_in   = n_ff - rb_in;
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         n_in   = n_ff;
         res_in = res_ff >> 1;
      end
   end

   // One step of the restoring divider.
   always_comb begin
      tr_in = {rem_ff, dvd_ff[64]};
      qb_in = (tr_in >= {1'b0, dvs_ff});
      if (qb_in) begin
         rem_in = 64'(tr_in - {1'b0, dvs_ff});
      end else begin
         rem_in = tr_in[63:0];
      end
      quo_in = {quo_ff[63:0], qb_in};
   end

   // Speed at or above light speed.
   always_comb begin
      inv_in = (acc_ff >= (67'd1 << 60));
      for (int i = 0; i < 3; i++) begin
         if (b_ff[i] >= 33'sd1073741824 || b_ff[i] <= -33'sd1073741824) begin
            inv_in = 1'b1;
         end
      end
   end

   // Velocity registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            old_ff[i] <= '0;
            new_ff[i] <= '0;
         end
      end else if (wr_in) begin
         unique case (csr_index)
            lbe_pkg::REG_OLD_VEL_X: old_ff[0] <= csr_data;
            lbe_pkg::REG_OLD_VEL_Y: old_ff[1] <= csr_data;
            lbe_pkg::REG_OLD_VEL_Z: old_ff[2] <= csr_data;
            lbe_pkg::REG_NEW_VEL_X: new_ff[0] <= csr_data;
            lbe_pkg::REG_NEW_VEL_Y: new_ff[1] <= csr_data;
            lbe_pkg::REG_NEW_VEL_Z: new_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CO_IDLE;
         dirty_ff <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            CO_IDLE: begin
               if (wr_in) begin
                  dirty_ff <= 1'b1;
               end else if (dirty_ff) begin
                  dirty_ff <= 1'b0;
                  state_ff <= CO_SQ;
                  cnt_ff   <= '0;
               end
            end
            CO_SQ: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd3) begin
                  state_ff <= CO_PREP;
               end
            end
            CO_PREP: begin
               cnt_ff   <= '0;
               state_ff <= inv_in ? CO_IDLE : CO_ROOT;
            end
            CO_ROOT: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) begin
                  cnt_ff   <= '0;
                  state_ff <= CO_DIVG;
               end
            end
            CO_DIVG: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd64) begin
                  cnt_ff   <= '0;
                  state_ff <= CO_DIVK;
               end
            end
            CO_DIVK: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd64) begin
                  cnt_ff   <= '0;
                  state_ff <= CO_IDLE;
               end
            end
            default: state_ff <= CO_IDLE;
         endcase
      end
   end

   // Sequencer datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         CO_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               b_ff[i] <= 33'(old_ff[i]) - 33'(new_ff[i]);
            end
            acc_ff <= '0;
         end
         CO_SQ: begin
            if (cnt_ff != 7'd3) begin
               sq_ff <= bsel_in * bsel_in;
            end
            if (cnt_ff != 7'd0) begin
               acc_ff <= acc_ff + 67'(unsigned'(sq_ff));
            end
         end
         CO_PREP: begin
            inv_ff <= inv_in;
            n_ff   <= (64'h1000_0000_0000_0000 - acc_ff[63:0]) << 2;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
            for (int i = 0; i < 3; i++) begin
               bneg_ff[i] <= b_ff[i][32];
               bmag_ff[i] <= b_ff[i][32] ? 30'(-b_ff[i]) : b_ff[i][29:0];
            end
         end
         CO_ROOT: begin
            n_ff   <= n_in;
            res_ff <= res_in;
            bit_ff <= bit_ff >> 2;
            if (cnt_ff == 7'd31) begin
               dvs_ff <= res_in;
               dvd_ff <= 65'd1 << 63;
               rem_ff <= '0;
               quo_ff <= '0;
            end
         end
         CO_DIVG: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            dvd_ff <= dvd_ff << 1;
            if (cnt_ff == 7'd64) begin
               g_ff   <= quo_in[62:0];
               dvs_ff <= 64'(quo_in[62:0]) + 64'(lbe_pkg::ONE_Q32);
               dvd_ff <= 65'd1 << 64;
               rem_ff <= '0;
               quo_ff <= '0;
            end
         end
         CO_DIVK: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            dvd_ff <= dvd_ff << 1;
            if (cnt_ff == 7'd64) begin
               k_ff <= g_ff - lbe_pkg::ONE_Q32 + 63'(quo_in[31:0]);
            end
         end
         default: ;
      endcase
   end

endmodule

### rtl/lorentz_boost_event.sv
// Lorentz boost of one spacetime event per clock while busy is low. An event is
// taken at every clock edge with start high and busy low, and its boosted result
// appears on rsp_data, marked by rsp_valid for one cycle, from the stage 13 result
// register; results cannot be held off. After reset and after any configuration
// write the coefficient sequencer derives gamma and k with a bitwise square root and
// two restoring divisions, keeping busy high meanwhile (when the relative speed is
// invalid it stops after the squares and the speed check); configuration writes are
// taken only while that sequencer is idle. Events are streamed through a
// thirteen-stage multiply pipeline, so the rate is one event per cycle while busy is low.
module lorentz_boost_event (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  lbe_pkg::lbe_req_type               req_data,
   output logic                               rsp_valid,
   output lbe_pkg::lbe_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbe_pkg::DATA_W-1:0]         csr_data
);

   lbe_pkg::lbe_coef_type coef;
   logic                  calc_busy;
   logic                  acc_in;

   logic [lbe_pkg::PIPE_DEPTH-2:0] vld_ff;
   logic                           rsp_valid_ff;
   lbe_pkg::lbe_rsp_type           rsp_ff;

   // Carried coordinates.
   logic signed [31:0] t1_ff, t2_ff, t3_ff;
   logic signed [31:0] r_ff [11][3];
   logic               tneg1_ff, tneg2_ff, tneg3_ff;

   logic signed [62:0] s1_pr_ff [3];
   logic [31:0]        s1_tmag_ff;
   logic signed [63:0] s2_dsum_ff;
   logic [63:0]        s2_tl_ff;
   logic [62:0]        s2_th_ff;
   logic signed [33:0] s3_dot_ff;
   logic [62:0]        s3_p1m_ff;
   logic signed [34:0] s4_u_ff;
   logic [33:0]        s4_dmag_ff;
   logic               s4_dneg_ff;
   logic signed [63:0] s4_p1_ff, s5_p1_ff, s6_p1_ff, s7_p1_ff;
   logic [34:0]        s5_umag_ff;
   logic               s5_uneg_ff, s6_uneg_ff, s7_uneg_ff;
   logic               s5_dneg_ff, s6_dneg_ff;
   logic [65:0]        s5_dl_ff;
   logic [64:0]        s5_dh_ff;
   logic [66:0]        s6_ul_ff;
   logic [65:0]        s6_uh_ff;
   logic [62:0]        s6_p2m_ff, s7_p0m_ff;
   logic signed [63:0] s7_p2_ff;
   logic signed [63:0] res0_ff [8:12];
   logic signed [64:0] s8_w_ff;
   logic [63:0]        s9_wmag_ff;
   logic               s9_wneg_ff, s10_wneg_ff, s11_wneg_ff;
   logic [61:0]        s10_wl_ff [3];
   logic [61:0]        s10_wh_ff [3];
   logic [62:0]        s11_p3m_ff [3];
   logic signed [64:0] s12_res_ff [3];

   logic signed [63:0] dadj_in;
   logic [32:0]        sat_in [4];

   lbe_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .calc_busy (calc_busy),
      .coef      (coef)
   );

   assign busy   = reset || calc_busy;
   assign acc_in = start && !busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Valid bits move with the events.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[lbe_pkg::PIPE_DEPTH-3:0], acc_in};
         rsp_valid_ff <= vld_ff[lbe_pkg::PIPE_DEPTH-2];
      end
   end

   // Truncation of the dot product toward zero.
   assign dadj_in = s2_dsum_ff + (s2_dsum_ff[63] ? 64'sd1073741823 : 64'sd0);

   // Output saturation.
   always_comb begin
      sat_in[0] = lbe_pkg::sat32(65'(res0_ff[12]));
      for (int i = 0; i < 3; i++) begin
         sat_in[i+1] = lbe_pkg::sat32(s12_res_ff[i]);
      end
   end

   // Arithmetic pipeline.
   always_ff @(posedge clock) begin
      // Stage 1: b.r products and |t|.
      t1_ff      <= req_data.event_t;
      r_ff[0][0] <= req_data.event_x;
      r_ff[0][1] <= req_data.event_y;
      r_ff[0][2] <= req_data.event_z;
      s1_pr_ff[0] <= $signed(coef.b[0]) * req_data.event_x;
      s1_pr_ff[1] <= $signed(coef.b[1]) * req_data.event_y;
      s1_pr_ff[2] <= $signed(coef.b[2]) * req_data.event_z;
      tneg1_ff   <= req_data.event_t[31];
      s1_tmag_ff <= req_data.event_t[31] ? 32'(-req_data.event_t) : req_data.event_t;

      // Stage 2: dot sum and t*gamma partial products.
      t2_ff      <= t1_ff;
      tneg2_ff   <= tneg1_ff;
      s2_dsum_ff <= 64'(s1_pr_ff[0]) + 64'(s1_pr_ff[1]) + 64'(s1_pr_ff[2]);
      s2_tl_ff   <= s1_tmag_ff * coef.g[31:0];
      s2_th_ff   <= 63'(s1_tmag_ff * coef.g[62:32]);

      // Stage 3: b.r in Q16.16 and |t*gamma|.
      t3_ff     <= t2_ff;
      tneg3_ff  <= tneg2_ff;
      s3_dot_ff <= dadj_in[63:30];
      s3_p1m_ff <= lbe_pkg::clamp62(96'(s2_tl_ff >> 32) + 96'(s2_th_ff));

      // Stage 4: t + b.r, |b.r| and signed t*gamma.
      s4_u_ff    <= 35'(t3_ff) + 35'(s3_dot_ff);
      s4_dneg_ff <= s3_dot_ff[33];
      s4_dmag_ff <= s3_dot_ff[33] ? 34'(-s3_dot_ff) : s3_dot_ff;
      s4_p1_ff   <= tneg3_ff ? -$signed({1'b0, s3_p1m_ff}) : $signed({1'b0, s3_p1m_ff});

      // Stage 5: (b.r)*k partial products and |t + b.r|.
      s5_p1_ff   <= s4_p1_ff;
      s5_dneg_ff <= s4_dneg_ff;
      s5_uneg_ff <= s4_u_ff[34];
      s5_umag_ff <= s4_u_ff[34] ? 35'(-s4_u_ff) : s4_u_ff;
      s5_dl_ff   <= s4_dmag_ff * coef.k[31:0];
      s5_dh_ff   <= 65'(s4_dmag_ff * coef.k[62:32]);

      // Stage 6: (t + b.r)*gamma partial products and |(b.r)*k|.
      s6_p1_ff   <= s5_p1_ff;
      s6_dneg_ff <= s5_dneg_ff;
      s6_uneg_ff <= s5_uneg_ff;
      s6_ul_ff   <= s5_umag_ff * coef.g[31:0];
      s6_uh_ff   <= 66'(s5_umag_ff * coef.g[62:32]);
      s6_p2m_ff  <= lbe_pkg::clamp62(96'(s5_dl_ff >> 32) + 96'(s5_dh_ff));

      // Stage 7: |t'| and signed (b.r)*k.
      s7_p1_ff   <= s6_p1_ff;
      s7_uneg_ff <= s6_uneg_ff;
      s7_p0m_ff  <= lbe_pkg::clamp62(96'(s6_ul_ff >> 32) + 96'(s6_uh_ff));
      s7_p2_ff   <= s6_dneg_ff ? -$signed({1'b0, s6_p2m_ff}) : $signed({1'b0, s6_p2m_ff});

      // Stage 8: t' and w = gamma*t + k*(b.r).
      res0_ff[8] <= s7_uneg_ff ? -$signed({1'b0, s7_p0m_ff}) : $signed({1'b0, s7_p0m_ff});
      s8_w_ff    <= 65'(s7_p1_ff) + 65'(s7_p2_ff);

      // Stage 9: |w|.
      res0_ff[9] <= res0_ff[8];
      s9_wneg_ff <= s8_w_ff[64];
      s9_wmag_ff <= s8_w_ff[64] ? 64'(-s8_w_ff) : s8_w_ff[63:0];

      // Stage 10: w*beta partial products per axis.
      res0_ff[10] <= res0_ff[9];
      s10_wneg_ff <= s9_wneg_ff;
      for (int i = 0; i < 3; i++) begin
         s10_wl_ff[i] <= s9_wmag_ff[31:0] * coef.bmag[i];
         s10_wh_ff[i] <= s9_wmag_ff[63:32] * coef.bmag[i];
      end

      // Stage 11: |w*beta| per axis.
      res0_ff[11] <= res0_ff[10];
      s11_wneg_ff <= s10_wneg_ff;
      for (int i = 0; i < 3; i++) begin
         s11_p3m_ff[i] <= lbe_pkg::clamp62(96'(s10_wl_ff[i] >> 30) + (96'(s10_wh_ff[i]) << 2));
      end

      // Stage 12: r' = r + w*beta.
      res0_ff[12] <= res0_ff[11];
      for (int i = 0; i < 3; i++) begin
         if (s11_wneg_ff ^ coef.bneg[i]) begin
            s12_res_ff[i] <= 65'(r_ff[10][i]) - $signed({2'b00, s11_p3m_ff[i]});
         end else begin
            s12_res_ff[i] <= 65'(r_ff[10][i]) + $signed({2'b00, s11_p3m_ff[i]});
         end
      end

      // Stage 13: saturation and the result register.
      if (coef.invalid) begin
         rsp_ff.boosted_t     <= '0;
         rsp_ff.boosted_x     <= '0;
         rsp_ff.boosted_y     <= '0;
         rsp_ff.boosted_z     <= '0;
         rsp_ff.speed_invalid <= 1'b1;
         rsp_ff.clipped       <= 1'b0;
      end else begin
         rsp_ff.boosted_t     <= sat_in[0][31:0];
         rsp_ff.boosted_x     <= sat_in[1][31:0];
         rsp_ff.boosted_y     <= sat_in[2][31:0];
         rsp_ff.boosted_z     <= sat_in[3][31:0];
         rsp_ff.speed_invalid <= 1'b0;
         rsp_ff.clipped       <= sat_in[0][32] | sat_in[1][32] | sat_in[2][32] |
                                 sat_in[3][32];
      end
   end

   // Spatial coordinates ride along the pipeline.
   always_ff @(posedge clock) begin
      for (int s = 1; s < 11; s++) begin
         r_ff[s] <= r_ff[s-1];
      end
   end

   // Every accepted request gives a result a fixed time later.
   assert property (@(posedge clock) disable iff (reset)
      acc_in |-> ##(lbe_pkg::PIPE_DEPTH) rsp_valid)
      else $error("accepted request gives no result");

   // Every result comes from an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc_in, lbe_pkg::PIPE_DEPTH))
      else $error("result strobe without an accepted request");

   // A speed at or above light speed returns zeros (t and x checked) and no clip flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.speed_invalid |->
         !rsp_data.clipped && rsp_data.boosted_t == 32'sd0 &&
         rsp_data.boosted_x == 32'sd0)
      else $error("invalid speed result is not cleared");

   // Finished coefficients: gamma at least one and k below gamma.
   assert property (@(posedge clock) disable iff (reset)
      $fell(calc_busy) && !coef.invalid |->
         coef.g >= lbe_pkg::ONE_Q32 && coef.k < coef.g)
      else $error("boost coefficients out of range");

   // No request is taken while the coefficients are being derived.
   assert property (@(posedge clock) disable iff (reset)
      calc_busy |-> !acc_in)
      else $error("request accepted during coefficient update");

endmodule
